// File: design/chash_pkg.sv
package chash_pkg;

	localparam int MAX_BUCKETS  = 16;
	localparam int BUCKET_DEPTH = 8;
	localparam int SLOT_TOTAL   = MAX_BUCKETS * BUCKET_DEPTH;

	localparam int KEY_W      = 31;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int CNT_W      = 5;
	localparam int BKT_W      = $clog2(MAX_BUCKETS);
	localparam int SLOT_W     = $clog2(BUCKET_DEPTH);
	localparam int ADDR_W     = $clog2(SLOT_TOTAL);
	localparam int DIV_CNT_W  = $clog2(KEY_W);
	localparam int SCAN_CNT_W = $clog2(BUCKET_DEPTH + 1);

	localparam logic [CNT_W-1:0] BUCKET_CNT_RESET = CNT_W'(10);

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_NOP    = 2'd3
	} chash_mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_FOUND  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} chash_status_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic scan_step;
		logic commit;
	} chash_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic div_last;
		logic need_scan;
		logic scan_done;
		logic out_free;
	} chash_sts_t;

endpackage

// File: design/chash_req_if.sv
interface chash_req_if;
	import chash_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  key;

	modport source(output valid, output mode, output key, input ready);
	modport sink(input valid, input mode, input key, output ready);
endinterface

// File: design/chash_rsp_if.sv
interface chash_rsp_if;
	import chash_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BKT_W-1:0]    bucket;

	modport source(output valid, output status, output bucket, input ready);
	modport sink(input valid, input status, input bucket, output ready);
endinterface

// File: design/chash_ram.sv
module chash_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/chash_ctrl.sv
module chash_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  chash_pkg::chash_sts_t sts,
	output chash_pkg::chash_cmd_t cmd
);
	import chash_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_SCAN = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_n  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = sts.need_scan ? S_SCAN : S_RESP;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_n = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

// File: design/chash_dpath.sv
module chash_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [chash_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic [chash_pkg::MODE_W-1:0]    req_mode,
	input  logic [chash_pkg::KEY_W-1:0]     req_key,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output logic [chash_pkg::STATUS_W-1:0]  rsp_status,
	output logic [chash_pkg::BKT_W-1:0]     rsp_bucket,
	input  chash_pkg::chash_cmd_t           cmd,
	output chash_pkg::chash_sts_t           sts
);
	import chash_pkg::*;

	logic [CNT_W-1:0]      bucket_count_q;
	logic [CNT_W-1:0]      eff_count;
	logic [CNT_W-1:0]      divisor_q;
	logic [KEY_W-1:0]      key_q;
	logic [MODE_W-1:0]     mode_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [BKT_W-1:0]      rem_q;
	logic [BKT_W:0]        trial;
	logic [BKT_W-1:0]      rem_n;
	logic [SCAN_CNT_W-1:0] scan_cnt_q;
	logic                  cmp_vld_s1;
	logic [SLOT_W-1:0]     cmp_slot_s1;
	logic                  hit_q;
	logic [SLOT_W-1:0]     hit_slot_q;
	logic                  issue;
	logic                  match;
	logic [SLOT_TOTAL-1:0] valid_q;
	logic [BUCKET_DEPTH-1:0] bkt_valid;
	logic [SLOT_W-1:0]     free_slot;
	logic                  bkt_full;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [KEY_W-1:0]      ram_rdata;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [BKT_W-1:0]      out_bucket_q;
	logic [STATUS_W-1:0]   status_n;

	// Zero counts as one bucket, anything past the table size saturates.
	always_comb begin
		if (bucket_count_q == '0) begin
			eff_count = CNT_W'(1);
		end else if (bucket_count_q > CNT_W'(MAX_BUCKETS)) begin
			eff_count = CNT_W'(MAX_BUCKETS);
		end else begin
			eff_count = bucket_count_q;
		end
	end

	// One restoring division step per cycle; the remainder stays below the divisor.
	assign trial = {rem_q, key_q[div_cnt_q]};
	assign rem_n = (trial >= divisor_q) ? BKT_W'(trial - divisor_q) : trial[BKT_W-1:0];

	assign bkt_valid = valid_q[{rem_q, {SLOT_W{1'b0}}} +: BUCKET_DEPTH];
	assign bkt_full  = &bkt_valid;

	always_comb begin
		free_slot = '0;
		for (int i = BUCKET_DEPTH - 1; i >= 0; i--) begin
			if (!bkt_valid[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign issue     = cmd.scan_step && (scan_cnt_q != SCAN_CNT_W'(BUCKET_DEPTH));
	assign ram_raddr = {rem_q, scan_cnt_q[SLOT_W-1:0]};
	assign match     = cmp_vld_s1 && !hit_q && valid_q[{rem_q, cmp_slot_s1}]
	                   && (ram_rdata == key_q);
	assign ram_we    = cmd.commit && (mode_q == MODE_INSERT) && !bkt_full;

	chash_ram #(
		.WIDTH(KEY_W),
		.DEPTH(SLOT_TOTAL)
	) u_keys (
		.clk  (clk),
		.we   (ram_we),
		.waddr({rem_q, free_slot}),
		.wdata(key_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		case (mode_q)
			MODE_INSERT: status_n = bkt_full ? ST_FULL : ST_DONE;
			MODE_DELETE: status_n = hit_q ? ST_FOUND : ST_ABSENT;
			MODE_SEARCH: status_n = hit_q ? ST_FOUND : ST_ABSENT;
			default:     status_n = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_CNT_RESET;
			div_cnt_q      <= '0;
			scan_cnt_q     <= '0;
			cmp_vld_s1     <= 1'b0;
			hit_q          <= 1'b0;
			valid_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				bucket_count_q <= cfg_wdata;
			end
			if (cmd.load) begin
				div_cnt_q  <= DIV_CNT_W'(KEY_W - 1);
				scan_cnt_q <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end else begin
				if (cmd.div_step && (div_cnt_q != '0)) begin
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
				end
				if (issue) begin
					scan_cnt_q <= scan_cnt_q + SCAN_CNT_W'(1);
				end
				cmp_vld_s1 <= issue;
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (ram_we) begin
				valid_q[{rem_q, free_slot}] <= 1'b1;
			end
			if (cmd.commit && (mode_q == MODE_DELETE) && hit_q) begin
				valid_q[{rem_q, hit_slot_q}] <= 1'b0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q     <= req_key;
			mode_q    <= req_mode;
			rem_q     <= '0;
			divisor_q <= eff_count;
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
		end
		if (issue) begin
			cmp_slot_s1 <= scan_cnt_q[SLOT_W-1:0];
		end
		if (match) begin
			hit_slot_q <= cmp_slot_s1;
		end
		if (cmd.commit) begin
			out_status_q <= status_n;
			out_bucket_q <= rem_q;
		end
	end

	assign sts.div_last  = (div_cnt_q == '0);
	assign sts.need_scan = (mode_q == MODE_DELETE) || (mode_q == MODE_SEARCH);
	assign sts.scan_done = hit_q || ((scan_cnt_q == SCAN_CNT_W'(BUCKET_DEPTH)) && !cmp_vld_s1);
	assign sts.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_bucket = out_bucket_q;
endmodule

// File: design/chained_hash_table.sv
// Hash table of 31-bit keys in 16 buckets of 8 slots, bucket = key mod bucket count.
// The req channel carries an item with a mode (insert, delete, search, or a no-op
// code) and a key; the rsp channel returns one item per request with a status and
// the bucket the key hashes to. cfg_we/cfg_wdata write the bucket count, which is
// meant to change only while no request is outstanding.
// Each request first runs a bit-serial modulo, one key bit per cycle. Inserts and
// no-ops then skip the bucket walk and go straight to registering the response.
// Deletes and searches walk their bucket through the key RAM, one read per cycle
// with the compare in the cycle after each read, stopping at the first hit.
// One request is in flight at a time; req.ready rises again at the edge that
// registers the response, so a new item is taken while the previous response
// still waits in the output register.
// If the receiver stalls, the response is held and the next request finishes its
// work and then waits in its final state.
// Reset empties every bucket (slot valid bits cleared at once, no sweep), sets
// the bucket count to 10 and leaves both channels idle.
module chained_hash_table (
	input  logic                        clk,
	input  logic                        arst_n,
	chash_req_if.sink                   req,
	chash_rsp_if.source                 rsp,
	input  logic                        cfg_we,
	input  logic [chash_pkg::CNT_W-1:0] cfg_wdata
);
	import chash_pkg::*;

	chash_cmd_t cmd;
	chash_sts_t sts;

	// Controller: sequences modulo, bucket scan and response.
	chash_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: register, divider, key RAM, valid bits and the output register.
	chash_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_mode  (req.mode),
		.req_key   (req.key),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_status(rsp.status),
		.rsp_bucket(rsp.bucket),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

// File: design/chash_checker.sv
module chash_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready
);
	// A response item waits until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// Only one request is in flight.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// A response never appears the cycle straight after a request is taken.
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response too early");

	// Registering a fresh response frees the request side in the same cycle.
	a_ready_after_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("request side not freed after response");
endmodule

bind chained_hash_table chash_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready)
);

// File: tb/sv/tb_chained_hash_table.sv
module tb_chained_hash_table;
	import chash_pkg::*;

	// One answer from the table: the status and the bucket the key hashes to.
	typedef struct packed {
		chash_status_t          status;
		logic [BKT_W-1:0]       bucket;
	} table_answer_t;

	// One row of the opening sequence. Where the answer can be read off at a
	// glance it is typed in and flagged; every other row is left to the
	// table mirror below.
	typedef struct packed {
		chash_mode_t            mode;
		logic [KEY_W-1:0]       key;
		logic                   typed;
		chash_status_t          status;
		logic [BKT_W-1:0]       bucket;
	} probe_row_t;

	localparam int PROBE_ROWS = 24;
	localparam int PHASES     = 9;
	localparam int PHASE_LEN  = 100;
	localparam int HOLD_LEN   = 300;
	localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	chash_req_if req();
	chash_rsp_if rsp();

	chained_hash_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the table: the stored keys, their valid bits and the bucket
	// count as last written. Keys are only compared where the valid bit is
	// set, so the undefined reset contents never matter.
	logic [KEY_W-1:0] slot_key [SLOT_TOTAL];
	logic             slot_used[SLOT_TOTAL];
	logic [CNT_W-1:0] live_count;

	// Answers still owed by the block, oldest first.
	table_answer_t pending_answers[$];
	int mismatches = 0;

	// Shared between the request side and the response side: calm switches
	// off idling on both, and hold_off_req asks the response side for one
	// long stall.
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;

	// Keys inserted lately, so that searches and deletes mostly find
	// something and buckets fill up.
	logic [KEY_W-1:0] key_pool[$];

	// The opening sequence runs with the reset bucket count of ten. It walks
	// the extreme keys, every mode, a duplicate insert followed by a delete
	// that must free only the lower copy, a bucket filled to the brim and
	// the refill of a slot freed in the middle of a full bucket.
	probe_row_t probes[PROBE_ROWS] = '{
		'{MODE_SEARCH, 31'd0,          1'b1, ST_ABSENT, 4'd0},
		'{MODE_INSERT, KEY_TOP,        1'b1, ST_DONE,   4'd7},
		'{MODE_SEARCH, KEY_TOP,        1'b1, ST_FOUND,  4'd7},
		'{MODE_DELETE, KEY_TOP,        1'b1, ST_FOUND,  4'd7},
		'{MODE_DELETE, KEY_TOP,        1'b1, ST_ABSENT, 4'd7},
		'{MODE_NOP,    31'd13,         1'b1, ST_DONE,   4'd3},
		'{MODE_INSERT, 31'd0,          1'b1, ST_DONE,   4'd0},
		'{MODE_INSERT, 31'd0,          1'b0, ST_DONE,   4'd0},
		'{MODE_DELETE, 31'd0,          1'b0, ST_DONE,   4'd0},
		'{MODE_SEARCH, 31'd0,          1'b0, ST_DONE,   4'd0},
		'{MODE_INSERT, 31'd5,          1'b1, ST_DONE,   4'd5},
		'{MODE_INSERT, 31'd15,         1'b1, ST_DONE,   4'd5},
		'{MODE_INSERT, 31'd25,         1'b1, ST_DONE,   4'd5},
		'{MODE_INSERT, 31'd35,         1'b1, ST_DONE,   4'd5},
		'{MODE_INSERT, 31'd45,         1'b1, ST_DONE,   4'd5},
		'{MODE_INSERT, 31'd55,         1'b1, ST_DONE,   4'd5},
		'{MODE_INSERT, 31'd65,         1'b1, ST_DONE,   4'd5},
		'{MODE_INSERT, 31'd75,         1'b1, ST_DONE,   4'd5},
		'{MODE_INSERT, 31'd85,         1'b1, ST_FULL,   4'd5},
		'{MODE_SEARCH, 31'd85,         1'b1, ST_ABSENT, 4'd5},
		'{MODE_DELETE, 31'd35,         1'b0, ST_DONE,   4'd0},
		'{MODE_INSERT, 31'd85,         1'b0, ST_DONE,   4'd0},
		'{MODE_SEARCH, 31'h2AAA_AAAA,  1'b0, ST_DONE,   4'd0},
		'{MODE_SEARCH, 31'h5555_5555,  1'b0, ST_DONE,   4'd0}
	};

	// Bucket counts for the random phases. Zero and thirty-one are the
	// register extremes and must behave as one and sixteen; the last phase
	// picks its own count.
	logic [CNT_W-1:0] phase_counts[PHASES] = '{
		5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd7, 5'd13, 5'd10
	};

	// The clock has a period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Works out the answer to one accepted request and updates the mirror
	// exactly as the table itself should.
	function automatic table_answer_t hash_request(input chash_mode_t mode,
			input logic [KEY_W-1:0] key);
		int divisor;
		int b;
		int base;
		int hit;
		table_answer_t answer;
		divisor = int'(live_count);
		if (divisor < 1)
			divisor = 1;
		if (divisor > MAX_BUCKETS)
			divisor = MAX_BUCKETS;
		b = int'(32'(key) % 32'(divisor));
		base = b * BUCKET_DEPTH;
		answer.bucket = BKT_W'(b);
		answer.status = ST_DONE;
		case (mode)
			MODE_INSERT: begin
				// The lowest free slot takes the key; with none free the
				// bucket is reported full and nothing is stored.
				answer.status = ST_FULL;
				for (int s = 0; s < BUCKET_DEPTH; s++) begin
					if (!slot_used[base + s]) begin
						slot_used[base + s] = 1'b1;
						slot_key[base + s] = key;
						answer.status = ST_DONE;
						break;
					end
				end
			end
			MODE_DELETE, MODE_SEARCH: begin
				hit = -1;
				for (int s = 0; s < BUCKET_DEPTH; s++) begin
					if (slot_used[base + s] && slot_key[base + s] == key) begin
						hit = s;
						break;
					end
				end
				answer.status = (hit >= 0) ? ST_FOUND : ST_ABSENT;
				// Only the lowest copy of a duplicated key is freed.
				if (mode == MODE_DELETE && hit >= 0)
					slot_used[base + hit] = 1'b0;
			end
			default: begin
				// The spare mode code does nothing but still reports the bucket.
				answer.status = ST_DONE;
			end
		endcase
		return answer;
	endfunction

	// Offers one request, waits for the block to take it, and then records
	// the answer it is owed. A typed answer overrides the mirror's, but the
	// mirror still sees the request so that its contents stay right.
	task automatic send_request(input chash_mode_t mode, input logic [KEY_W-1:0] key,
			input logic typed, input chash_status_t status,
			input logic [BKT_W-1:0] bucket);
		table_answer_t answer;
		while (!calm && $urandom_range(0, 99) < 16) begin
			req.valid <= 1'b0;
			req.mode <= chash_mode_t'($urandom_range(0, 3));
			req.key <= KEY_W'($urandom);
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= mode;
		req.key <= key;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		answer = hash_request(mode, key);
		if (typed) begin
			answer.status = status;
			answer.bucket = bucket;
		end
		pending_answers = {pending_answers, answer};
	endtask

	// The bucket count may only change while the block holds nothing, so
	// the request side goes quiet and every owed answer is collected first.
	task automatic set_bucket_count(input logic [CNT_W-1:0] count);
		req.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		live_count = count;
	endtask

	// Request side: reset, the opening sequence, then the random phases.
	initial begin : drive_requests
		int roll;
		chash_mode_t mode;
		logic [KEY_W-1:0] key;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req.valid <= 1'b0;
		req.mode <= MODE_NOP;
		req.key <= '0;
		live_count = BUCKET_CNT_RESET;
		for (int i = 0; i < SLOT_TOTAL; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i])
			send_request(probes[i].mode, probes[i].key, probes[i].typed,
				probes[i].status, probes[i].bucket);

		phase_counts[PHASES-1] = CNT_W'($urandom_range(2, 15));
		for (int phase = 0; phase < PHASES; phase++) begin
			set_bucket_count(phase_counts[phase]);
			// One phase runs with no idling anywhere; another opens with a
			// long stall on the response side while requests keep coming,
			// so that the block backs up and stops taking items.
			calm = (phase == 4);
			if (phase == 2)
				hold_off_req = 1'b1;
			for (int i = 0; i < PHASE_LEN; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 40)
					mode = MODE_INSERT;
				else if (roll < 65)
					mode = MODE_DELETE;
				else if (roll < 95)
					mode = MODE_SEARCH;
				else
					mode = MODE_NOP;
				roll = $urandom_range(0, 99);
				if (roll < 10)
					key = KEY_W'($urandom);
				else if (roll < 60 && key_pool.size() != 0)
					key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				else
					key = KEY_W'($urandom_range(0, 255));
				if (mode == MODE_INSERT) begin
					key_pool = {key_pool, key};
					if (key_pool.size() > 48)
						void'(key_pool.pop_front());
				end
				send_request(mode, key, 1'b0, ST_DONE, '0);
			end
		end

		// Drain: every owed answer must arrive, then a quiet spell in which
		// no stray answer may appear.
		req.valid <= 1'b0;
		calm = 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Response side: ready drops at random about one cycle in six, not at
	// all in the calm phase, and for a long counted stretch when asked.
	initial begin : drain_answers
		int hold;
		hold = 0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold = HOLD_LEN;
			end
			if (hold > 0) begin
				hold = hold - 1;
				rsp.ready <= 1'b0;
			end else if (calm) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= 16);
			end
		end
	end

	// Every answer taken is compared with the oldest one owed.
	always @(posedge clk) begin : check_answers
		table_answer_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: answer with none owed: status=%0d bucket=%0d",
					$time, rsp.status, rsp.bucket);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, rsp.status);
					mismatches++;
				end
				if (rsp.bucket !== want.bucket) begin
					$display("%0t: bucket expected %0d, got %0d",
						$time, want.bucket, rsp.bucket);
					mismatches++;
				end
			end
		end
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		#1000000;
		$display("status: fail");
		$finish;
	end

endmodule
